// File: rtl/rscb_pkg.sv
`default_nettype none
package rscb_pkg;

   localparam int COLOR_BITS = 8;
   localparam int NUM_LANES = 3;
   localparam int CSR_WIDTH = 8;
   localparam int CSR_INDEX_W = 2;

   localparam int VSUM_W = COLOR_BITS + 2;
   localparam int DIFF_W = VSUM_W + 1;
   localparam int P1_W = 20;
   localparam int T_W = 30;
   localparam int QIN_W = 23;
   localparam int RECIP_W = 24;
   localparam int RECIP_SHIFT = 38;
   localparam int QPROD_W = QIN_W + RECIP_W;

   localparam int UNITY_PCT = 100;
   localparam int BRIGHT_SCALE = 76800;
   localparam int DIVISOR = 30000;
   localparam int CHAN_MAX = (1 << COLOR_BITS) - 1;
   localparam int SAT_LIMIT = (CHAN_MAX + 1) * DIVISOR;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR);

   localparam logic [CSR_INDEX_W-1:0] CSR_SATURATION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTRAST = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS = 2'd2;

   localparam logic [CSR_WIDTH-1:0] SAT_RESET = 8'd100;
   localparam logic [CSR_WIDTH-1:0] CON_RESET = 8'd100;
   localparam logic [CSR_WIDTH-1:0] BRI_RESET = 8'd0;

   typedef struct packed {
      logic b;
      logic c;
      logic d;
   } pipe_en_type;

   typedef struct packed {
      logic                  neg;
      logic                  over;
      logic [COLOR_BITS-1:0] quo;
   } lane_res_type;

endpackage
`default_nettype wire

// File: rtl/rgb_saturation_contrast_brightness.sv
// RGB saturation / contrast / brightness adjust.
// Input channel req_*: one RGB color per transaction, valid/ready.
// Output channel rsp_*: the adjusted color, valid/ready, one result per input.
// Config port csr_*: write csr_wdata to register csr_index when csr_we is high:
//   0 saturation (percent), 1 contrast (percent), 2 brightness (signed percent).
//   Other indexes are ignored. Write only while the pipeline is empty.
// Each input transaction passes the input register, lane stages b, c and d and the output register before rsp_valid.
// Throughput: one color per clock while rsp_ready allows; three channel lanes run in
// parallel, each a three-stage multiply pipeline, followed by a shared clamp/output register.
// Each stage holds its data only while occupied and blocked, so bubbles
// collapse and inputs keep being taken while a finished result waits.
// A sustained rsp_ready low fills the pipe and then drops req_ready.
// Reset (synchronous): pipeline empty, saturation 100, contrast 100,
// brightness 0.
`default_nettype none
module rgb_saturation_contrast_brightness (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire [rscb_pkg::COLOR_BITS-1:0]    req_red_in,
   input  wire [rscb_pkg::COLOR_BITS-1:0]    req_green_in,
   input  wire [rscb_pkg::COLOR_BITS-1:0]    req_blue_in,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [rscb_pkg::COLOR_BITS-1:0]   rsp_red_out,
   output logic [rscb_pkg::COLOR_BITS-1:0]   rsp_green_out,
   output logic [rscb_pkg::COLOR_BITS-1:0]   rsp_blue_out,
   input  wire                               csr_we,
   input  wire [rscb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire [rscb_pkg::CSR_WIDTH-1:0]     csr_wdata
);
   import rscb_pkg::*;

   logic [CSR_WIDTH-1:0] sat_ff, sat_in;
   logic [CSR_WIDTH-1:0] con_ff, con_in;
   logic [CSR_WIDTH-1:0] bri_ff, bri_in;

   logic valid_a_ff, valid_a_in;
   logic valid_b_ff, valid_b_in;
   logic valid_c_ff, valid_c_in;
   logic valid_d_ff, valid_d_in;
   logic valid_o_ff, valid_o_in;

   logic en_a, en_o;
   pipe_en_type en;

   logic [COLOR_BITS-1:0] chan_ff [NUM_LANES];
   logic [COLOR_BITS-1:0] chan_in [NUM_LANES];
   logic [VSUM_W-1:0]     vsum_ff, vsum_in;
   lane_res_type          lane_res [NUM_LANES];

   // config registers
   always_comb begin
      sat_in = sat_ff;
      con_in = con_ff;
      bri_in = bri_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SATURATION: sat_in = csr_wdata;
            CSR_CONTRAST:   con_in = csr_wdata;
            CSR_BRIGHTNESS: bri_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= SAT_RESET;
         con_ff <= CON_RESET;
         bri_ff <= BRI_RESET;
      end else begin
         sat_ff <= sat_in;
         con_ff <= con_in;
         bri_ff <= bri_in;
      end
   end

   // stage enables, bubble collapsing
   assign en_o = !valid_o_ff || rsp_ready;
   assign en.d = !valid_d_ff || en_o;
   assign en.c = !valid_c_ff || en.d;
   assign en.b = !valid_b_ff || en.c;
   assign en_a = !valid_a_ff || en.b;
   assign req_ready = en_a;

   assign valid_a_in = en_a ? req_valid : valid_a_ff;
   assign valid_b_in = en.b ? valid_a_ff : valid_b_ff;
   assign valid_c_in = en.c ? valid_b_ff : valid_c_ff;
   assign valid_d_in = en.d ? valid_c_ff : valid_d_ff;
   assign valid_o_in = en_o ? valid_d_ff : valid_o_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
         valid_o_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
         valid_c_ff <= valid_c_in;
         valid_d_ff <= valid_d_in;
         valid_o_ff <= valid_o_in;
      end
   end

   // input stage
   assign chan_in[0] = req_red_in;
   assign chan_in[1] = req_green_in;
   assign chan_in[2] = req_blue_in;
   assign vsum_in = VSUM_W'(req_red_in) + VSUM_W'(req_green_in) + VSUM_W'(req_blue_in);

   always_ff @(posedge clock) begin
      if (en_a) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            chan_ff[i] <= chan_in[i];
         end
         vsum_ff <= vsum_in;
      end
   end

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      rscb_lane u_lane (
         .clock (clock),
         .en    (en),
         .chan  (chan_ff[i]),
         .vsum  (vsum_ff),
         .sat   (sat_ff),
         .con   (con_ff),
         .bri   ($signed(bri_ff)),
         .res   (lane_res[i])
      );
   end

   rscb_merge u_merge (
      .clock     (clock),
      .en        (en_o),
      .res       (lane_res),
      .red_out   (rsp_red_out),
      .green_out (rsp_green_out),
      .blue_out  (rsp_blue_out)
   );

   assign rsp_valid = valid_o_ff;

   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_o_ff |-> req_ready)
      else $error("req_ready low with empty output stage");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_a_ff)
      else $error("accepted transaction did not enter pipeline");

   a_blocked_holds: assert property (@(posedge clock) disable iff (reset)
      valid_d_ff && !en.d |=> valid_d_ff && valid_o_ff)
      else $error("blocked stage lost its transaction");

   a_out_from_d: assert property (@(posedge clock) disable iff (reset)
      en_o && valid_d_ff |=> valid_o_ff)
      else $error("output stage missed a result");

   a_reset_cfg: assert property (@(posedge clock)
      reset |=> sat_ff == SAT_RESET && con_ff == CON_RESET && bri_ff == BRI_RESET)
      else $error("config registers not at reset value");

endmodule
`default_nettype wire

// File: rtl/rscb_lane.sv
`default_nettype none
module rscb_lane (
   input  wire                              clock,
   input  rscb_pkg::pipe_en_type            en,
   input  wire [rscb_pkg::COLOR_BITS-1:0]   chan,
   input  wire [rscb_pkg::VSUM_W-1:0]       vsum,
   input  wire [rscb_pkg::CSR_WIDTH-1:0]    sat,
   input  wire [rscb_pkg::CSR_WIDTH-1:0]    con,
   input  wire signed [rscb_pkg::CSR_WIDTH-1:0] bri,
   output rscb_pkg::lane_res_type           res
);
   import rscb_pkg::*;

   logic [VSUM_W-1:0]        c3;
   logic signed [DIFF_W-1:0] diff;
   logic signed [P1_W-1:0]   sat_term;
   logic [P1_W-1:0]          unity_term;
   logic signed [P1_W-1:0]   p1_in, p1_ff;
   logic signed [T_W-1:0]    con_term;
   logic signed [T_W-1:0]    bri_term;
   logic signed [T_W-1:0]    t_in, t_ff;
   logic [QPROD_W-1:0]       qprod;
   lane_res_type             res_in, res_ff;

   assign c3 = VSUM_W'(chan) + {1'b0, chan, 1'b0};
   assign diff = $signed({1'b0, c3}) - $signed({1'b0, vsum});
   assign sat_term = P1_W'(diff) * P1_W'($signed({1'b0, sat}));
   assign unity_term = P1_W'(vsum) * P1_W'(UNITY_PCT);
   assign p1_in = sat_term + $signed(unity_term);

   assign con_term = T_W'(p1_ff) * T_W'($signed({1'b0, con}));
   assign bri_term = T_W'(bri) * $signed(T_W'(BRIGHT_SCALE));
   assign t_in = con_term + bri_term;

   // reciprocal multiply, exact for t below 2^23
   assign qprod = QPROD_W'(t_ff[QIN_W-1:0]) * QPROD_W'(RECIP);
   assign res_in.neg = t_ff[T_W-1];
   assign res_in.over = !t_ff[T_W-1] && (t_ff >= $signed(T_W'(SAT_LIMIT)));
   assign res_in.quo = qprod[RECIP_SHIFT +: COLOR_BITS];

   always_ff @(posedge clock) begin
      if (en.b) begin
         p1_ff <= p1_in;
      end
      if (en.c) begin
         t_ff <= t_in;
      end
      if (en.d) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule
`default_nettype wire

// File: rtl/rscb_merge.sv
`default_nettype none
module rscb_merge (
   input  wire                            clock,
   input  wire                            en,
   input  rscb_pkg::lane_res_type         res [rscb_pkg::NUM_LANES],
   output logic [rscb_pkg::COLOR_BITS-1:0] red_out,
   output logic [rscb_pkg::COLOR_BITS-1:0] green_out,
   output logic [rscb_pkg::COLOR_BITS-1:0] blue_out
);
   import rscb_pkg::*;

   logic [COLOR_BITS-1:0] chan_in [NUM_LANES];
   logic [COLOR_BITS-1:0] chan_ff [NUM_LANES];

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         if (res[i].neg) begin
            chan_in[i] = '0;
         end else if (res[i].over) begin
            chan_in[i] = COLOR_BITS'(CHAN_MAX);
         end else begin
            chan_in[i] = res[i].quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            chan_ff[i] <= chan_in[i];
         end
      end
   end

   assign red_out = chan_ff[0];
   assign green_out = chan_ff[1];
   assign blue_out = chan_ff[2];

endmodule
`default_nettype wire

// File: test/color_adjust_checker.sv
`timescale 1ns / 1ps
module color_adjust_checker (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   input  wire                             req_ready,
   input  wire [rscb_pkg::COLOR_BITS-1:0]  req_red_in,
   input  wire [rscb_pkg::COLOR_BITS-1:0]  req_green_in,
   input  wire [rscb_pkg::COLOR_BITS-1:0]  req_blue_in,
   input  wire                             rsp_valid,
   input  wire                             rsp_ready,
   input  wire [rscb_pkg::COLOR_BITS-1:0]  rsp_red_out,
   input  wire [rscb_pkg::COLOR_BITS-1:0]  rsp_green_out,
   input  wire [rscb_pkg::COLOR_BITS-1:0]  rsp_blue_out,
   input  wire                             csr_we,
   input  wire [rscb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [rscb_pkg::CSR_WIDTH-1:0]   csr_wdata,
   output int                              error_count,
   output int                              colors_in_flight
);
   import rscb_pkg::*;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } color_type;

   color_type expected_colors[$];

   logic        [CSR_WIDTH-1:0] saturation = SAT_RESET;
   logic        [CSR_WIDTH-1:0] contrast = CON_RESET;
   logic signed [CSR_WIDTH-1:0] brightness = BRI_RESET;

   function automatic logic [COLOR_BITS-1:0] adjusted_level(input int unsigned level,
                                                            input int unsigned level_sum);
      longint scaled;
      longint quotient;
      scaled = ((3 * longint'(level) - longint'(level_sum)) * longint'(saturation)
                + UNITY_PCT * longint'(level_sum)) * longint'(contrast)
               + longint'(brightness) * BRIGHT_SCALE;
      // SV division truncates toward zero
      quotient = scaled / DIVISOR;
      if (quotient < 0)
         quotient = 0;
      if (quotient > CHAN_MAX)
         quotient = CHAN_MAX;
      return quotient[COLOR_BITS-1:0];
   endfunction

   task automatic check_field(input string field, input logic [COLOR_BITS-1:0] want,
                              input logic [COLOR_BITS-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : track
      color_type   want;
      int unsigned level_sum;
      if (reset) begin
         saturation = SAT_RESET;
         contrast = CON_RESET;
         brightness = BRI_RESET;
         expected_colors.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_colors.size() == 0) begin
               $error("response transaction with none expected: red %0d green %0d blue %0d",
                      rsp_red_out, rsp_green_out, rsp_blue_out);
               error_count++;
            end else begin
               want = expected_colors.pop_front();
               check_field("red_out", want.red, rsp_red_out);
               check_field("green_out", want.green, rsp_green_out);
               check_field("blue_out", want.blue, rsp_blue_out);
            end
         end
         if (req_valid && req_ready) begin
            level_sum = int'(req_red_in) + int'(req_green_in) + int'(req_blue_in);
            want.red = adjusted_level(req_red_in, level_sum);
            want.green = adjusted_level(req_green_in, level_sum);
            want.blue = adjusted_level(req_blue_in, level_sum);
            expected_colors.push_back(want);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SATURATION: saturation = csr_wdata;
               CSR_CONTRAST: contrast = csr_wdata;
               CSR_BRIGHTNESS: brightness = csr_wdata;
               default: ;
            endcase
         end
      end
      colors_in_flight <= expected_colors.size();
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import rscb_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int NUM_PHASES = 8;
   localparam int COLORS_PER_PHASE = 48;
   localparam int HOLD_CYCLES = 40;
   localparam int SETTLE_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [COLOR_BITS-1:0]  req_red_in = '0;
   logic [COLOR_BITS-1:0]  req_green_in = '0;
   logic [COLOR_BITS-1:0]  req_blue_in = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [COLOR_BITS-1:0]  rsp_red_out;
   logic [COLOR_BITS-1:0]  rsp_green_out;
   logic [COLOR_BITS-1:0]  rsp_blue_out;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0]   csr_wdata = '0;

   int error_count;
   int colors_in_flight;
   int quiet_cycles = 0;
   bit idle_enabled = 1'b1;
   bit hold_request = 1'b0;

   always #5 clock = ~clock;

   rgb_saturation_contrast_brightness dut (.*);

   color_adjust_checker checker_inst (.*);

   // saturation, contrast, brightness per phase; two phases are randomized
   int sat_table[NUM_PHASES] = '{0, 255, 200, 0, 255, 0, 0, 100};
   int con_table[NUM_PHASES] = '{0, 255, 200, 200, 100, 0, 0, 100};
   int bri_table[NUM_PHASES] = '{-128, 127, 100, -100, -1, 0, 0, 0};

   logic [COLOR_BITS-1:0] directed_colors[16][3] = '{
      '{0, 0, 0}, '{255, 255, 255}, '{255, 0, 0}, '{0, 255, 0},
      '{0, 0, 255}, '{255, 255, 0}, '{0, 255, 255}, '{255, 0, 255},
      '{128, 128, 128}, '{1, 2, 3}, '{254, 1, 128}, '{85, 170, 255},
      '{127, 128, 129}, '{200, 50, 100}, '{170, 85, 0}, '{1, 254, 1}
   };

   function automatic logic [COLOR_BITS-1:0] random_level();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return CHAN_MAX[COLOR_BITS-1:0];
         default: return COLOR_BITS'($urandom_range(0, CHAN_MAX));
      endcase
   endfunction

   task automatic send_color(input logic [COLOR_BITS-1:0] red, input logic [COLOR_BITS-1:0] green,
                             input logic [COLOR_BITS-1:0] blue);
      req_red_in <= red;
      req_green_in <= green;
      req_blue_in <= blue;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (idle_enabled && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (colors_in_flight != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [CSR_WIDTH-1:0] data);
      csr_index <= index;
      csr_wdata <= data;
      csr_we <= 1'b1;
      @(posedge clock);
   endtask

   task automatic set_adjust(input int saturation, input int contrast, input int brightness);
      write_csr(CSR_SATURATION, CSR_WIDTH'(saturation));
      write_csr(CSR_CONTRAST, CSR_WIDTH'(contrast));
      write_csr(CSR_BRIGHTNESS, CSR_WIDTH'(brightness));
      // out-of-range index must be ignored
      write_csr(CSR_UNUSED, CSR_WIDTH'($urandom_range(0, 255)));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // response side: random back-pressure plus one long hold
   initial begin
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      logic [COLOR_BITS-1:0] gray;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_colors[i])
         send_color(directed_colors[i][0], directed_colors[i][1], directed_colors[i][2]);
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase == 5) begin
            sat_table[phase] = $urandom_range(0, 255);
            con_table[phase] = $urandom_range(0, 255);
            bri_table[phase] = $urandom_range(0, 255) - 128;
         end else if (phase == 6) begin
            sat_table[phase] = $urandom_range(0, 200);
            con_table[phase] = $urandom_range(0, 200);
            bri_table[phase] = $urandom_range(0, 200) - 100;
         end
         set_adjust(sat_table[phase], con_table[phase], bri_table[phase]);
         idle_enabled = (phase != 3) && (phase != NUM_PHASES - 1);
         if (phase == 1)
            hold_request = 1'b1;
         for (int n = 0; n < COLORS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               gray = random_level();
               send_color(gray, gray, gray);
            end else begin
               send_color(random_level(), random_level(), random_level());
            end
         end
         drain();
      end

      if (error_count == 0 && colors_in_flight == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
